FILE: design/i2a_pkg.sv
// shared types and constants for the integer to ascii formatter
// no dependencies
`default_nettype none

package i2a_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);

  // ceil(2^35 / 10): floor(x * RECIP_TEN / 2^35) == floor(x / 10) for any 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;

  localparam logic [DIGIT_W-1:0] TEN = 4'd10;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } out_word_t;

  // one digit (0..15) to its uppercase ascii code
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < TEN) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CH_A + CHAR_W'(d - TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/i2a_div.sv
// shared radix divider: one registered stage, divides by ten or sixteen
// depends on i2a_pkg
`default_nettype none

module i2a_div (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic                           hex_i,
  input  wire logic [i2a_pkg::VALUE_W-1:0]    mag_i,
  output logic      [i2a_pkg::VALUE_W-1:0]    quo_o,
  output logic      [i2a_pkg::DIGIT_W-1:0]    rem_o
);

  localparam int unsigned PROD_W = 2 * i2a_pkg::VALUE_W;
  localparam int unsigned QDEC_W = PROD_W - i2a_pkg::RECIP_SHIFT;

  logic [PROD_W-1:0]           prod_d, prod_q;
  logic [i2a_pkg::VALUE_W-1:0] mag_q;
  logic                        hex_q;
  logic [QDEC_W-1:0]           qdec;
  logic [i2a_pkg::VALUE_W-1:0] qdec_ext, qten, diff;

  // reciprocal multiply for the decimal quotient
  assign prod_d = {{i2a_pkg::VALUE_W{1'b0}}, mag_i}
                * {{i2a_pkg::VALUE_W{1'b0}}, i2a_pkg::RECIP_TEN};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_i;
      hex_q  <= hex_i;
    end
  end

  assign qdec     = prod_q[PROD_W-1:i2a_pkg::RECIP_SHIFT];
  assign qdec_ext = i2a_pkg::VALUE_W'(qdec);
  // q * 10 as two shifted adds
  assign qten     = (qdec_ext << 3) + (qdec_ext << 1);
  assign diff     = mag_q - qten;

  always_comb begin
    if (hex_q) begin
      quo_o = mag_q >> i2a_pkg::DIGIT_W;
      rem_o = mag_q[i2a_pkg::DIGIT_W-1:0];
    end else begin
      quo_o = qdec_ext;
      rem_o = diff[i2a_pkg::DIGIT_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter: sequencer, digit store, output register
// depends on i2a_pkg and i2a_div
`default_nettype none

// Formats one 32-bit number per input word as ASCII text, one character per
// output word, most significant character first, with last set on the final
// character. op = 0 gives signed decimal (a leading '-' for negative values,
// the most negative value printing as -2147483648); op = 1 gives "0x" and then
// uppercase hex digits without leading zeros. Zero prints as a single '0'.
// Digits come out of one shared divider stage (reciprocal multiply by ten, or
// a four-bit shift for hex) least significant first and are parked in a small
// digit store, then read back in reverse. Each digit takes a pass through
// the S_LOAD and S_DIG states of that divider loop; then the sign or the
// prefix and the stored digits go to the output register one character at a
// time, waiting while it is full and stalled. in_stall_o is high from
// acceptance until the final character has entered the output register;
// that register lets the next number be accepted while the last character
// still waits for the consumer.
module integer_to_ascii_formatter (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire i2a_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output i2a_pkg::out_word_t      out_word_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a number
  localparam logic [2:0] S_LOAD = 3'd1;  // divider takes the running magnitude
  localparam logic [2:0] S_DIG  = 3'd2;  // divider result: store digit, loop or finish
  localparam logic [2:0] S_SIGN = 3'd3;  // send '-' or the '0' of the hex prefix
  localparam logic [2:0] S_X    = 3'd4;  // send the 'x' of the hex prefix
  localparam logic [2:0] S_OUT  = 3'd5;  // send stored digits, top first

  logic [2:0]                   state_d, state_q;
  logic [i2a_pkg::VALUE_W-1:0]  mag_d, mag_q;
  logic                         neg_d, neg_q;
  logic                         hex_d, hex_q;
  logic [i2a_pkg::CNT_W-1:0]    cnt_d, cnt_q;
  logic [i2a_pkg::DIGIT_W-1:0]  dig_q [i2a_pkg::NUM_DIGITS];
  logic                         dig_we;

  logic                         out_valid_d, out_valid_q;
  i2a_pkg::out_word_t           out_word_d, out_word_q;
  logic                         out_load;

  logic                         in_accept;
  logic                         in_neg;

  logic                         div_en;
  logic [i2a_pkg::VALUE_W-1:0]  div_quo;
  logic [i2a_pkg::DIGIT_W-1:0]  div_rem;

  i2a_div u_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .hex_i (hex_q),
    .mag_i (mag_q),
    .quo_o (div_quo),
    .rem_o (div_rem)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_neg      = (in_word_i.op == i2a_pkg::OP_DEC) && in_word_i.value[i2a_pkg::VALUE_W-1];

  // output register may take a new word when empty or being drained
  assign out_load    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign div_en = (state_q == S_LOAD);
  assign dig_we = (state_q == S_DIG);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    cnt_d       = cnt_q;
    out_valid_d = out_load ? 1'b0 : out_valid_q;
    out_word_d  = out_word_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          hex_d   = (in_word_i.op == i2a_pkg::OP_HEX);
          neg_d   = in_neg;
          // unsigned negate keeps the most negative value exact
          mag_d   = in_neg ? (~in_word_i.value + 1'b1) : in_word_i.value;
          cnt_d   = '0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_DIG;
      end
      S_DIG: begin
        mag_d = div_quo;
        if (div_quo == '0) begin
          // cnt_q now points at the most significant stored digit
          state_d = (hex_q || neg_q) ? S_SIGN : S_OUT;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_SIGN: begin
        if (out_load) begin
          out_valid_d          = 1'b1;
          out_word_d.char_code = hex_q ? i2a_pkg::CH_ZERO : i2a_pkg::CH_MINUS;
          out_word_d.last      = 1'b0;
          state_d              = hex_q ? S_X : S_OUT;
        end
      end
      S_X: begin
        if (out_load) begin
          out_valid_d          = 1'b1;
          out_word_d.char_code = i2a_pkg::CH_X;
          out_word_d.last      = 1'b0;
          state_d              = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d          = 1'b1;
          out_word_d.char_code = i2a_pkg::digit_char(dig_q[cnt_q]);
          out_word_d.last      = (cnt_q == '0);
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    hex_q      <= hex_d;
    out_word_q <= out_word_d;
  end

  // digit store, written least significant digit first
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      dig_q[cnt_q] <= div_rem;
    end
  end

  // an accepted number always starts a divider pass
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_LOAD))
    else $error("accepted number did not start conversion");

  // decimal remainder from the reciprocal divider must be a decimal digit
  a_dec_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG && !hex_q) |-> (div_rem < i2a_pkg::TEN))
    else $error("decimal remainder out of range");

  // digit count never runs past the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG) |-> (cnt_q < i2a_pkg::CNT_W'(i2a_pkg::NUM_DIGITS)))
    else $error("digit store index out of range");

  // sending the bottom digit flags the word as last and frees the input
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_load && cnt_q == '0)
      |=> (out_valid_o && out_word_o.last && state_q == S_IDLE))
    else $error("final character not flagged");

endmodule

`default_nettype wire

FILE: dv/tb_integer_to_ascii_formatter.sv
`timescale 1ns / 100ps
// self-checking testbench for integer_to_ascii_formatter: a directed table, then random numbers
// checked against a predictor; depends on i2a_pkg and the design sources only

module tb_integer_to_ascii_formatter;

  // longest text is a sign and ten digits
  localparam int          MAX_CHARS    = 11;
  localparam int unsigned TEXT_W       = 8 * MAX_CHARS;
  localparam int unsigned NUM_RANDOM   = 250;
  // long consumer hold-off, well past what the block can buffer
  localparam int unsigned HOLD_CYCLES  = 300;
  // quiet cycles after the last expected word, to catch stray output
  localparam int unsigned DRAIN_CYCLES = 40;
  // cycles with no word moving on either side before giving up
  localparam int unsigned IDLE_LIMIT   = 2000;

  // consumer stall styles, one per segment
  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_COIN,
    FLOW_GATED,
    FLOW_SPARSE
  } stall_style_e;

  // one directed row: the input word and, where it is obvious, its text typed in
  // (right-justified, zero bytes ahead of it); an all-zero text means predict it
  typedef struct packed {
    i2a_pkg::in_word_t word;
    logic [TEXT_W-1:0] text;
  } directed_row_t;

  localparam directed_row_t DIRECTED_TABLE [20] = '{
    '{'{i2a_pkg::OP_DEC, 32'h0000_0000}, "0"},
    '{'{i2a_pkg::OP_DEC, 32'h7FFF_FFFF}, "2147483647"},
    '{'{i2a_pkg::OP_DEC, 32'h8000_0000}, "-2147483648"},
    '{'{i2a_pkg::OP_DEC, 32'hFFFF_FFFF}, "-1"},
    '{'{i2a_pkg::OP_HEX, 32'h0000_0000}, "0x0"},
    '{'{i2a_pkg::OP_HEX, 32'hFFFF_FFFF}, "0xFFFFFFFF"},
    '{'{i2a_pkg::OP_HEX, 32'h8000_0000}, "0x80000000"},
    '{'{i2a_pkg::OP_DEC, 32'd9},         ""},
    '{'{i2a_pkg::OP_DEC, 32'd10},        ""},
    '{'{i2a_pkg::OP_DEC, 32'd999999999}, ""},
    '{'{i2a_pkg::OP_DEC, 32'd1000000000}, ""},
    '{'{i2a_pkg::OP_DEC, 32'hFFFF_FFF6}, ""},
    '{'{i2a_pkg::OP_DEC, 32'h8000_0001}, ""},
    '{'{i2a_pkg::OP_DEC, 32'h5555_5555}, ""},
    '{'{i2a_pkg::OP_DEC, 32'hAAAA_AAAA}, ""},
    '{'{i2a_pkg::OP_HEX, 32'h0000_000A}, ""},
    '{'{i2a_pkg::OP_HEX, 32'h0000_0010}, ""},
    '{'{i2a_pkg::OP_HEX, 32'h0000_F00D}, ""},
    '{'{i2a_pkg::OP_HEX, 32'h1234_5678}, ""},
    '{'{i2a_pkg::OP_HEX, 32'h9ABC_DEF0}, ""}
  };

  // decimal boundaries, where the digit count changes
  localparam logic [i2a_pkg::VALUE_W-1:0] POW_TEN [10] = '{
    32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
    32'd10000000, 32'd100000000, 32'd1000000000
  };

  logic               clk_i;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  i2a_pkg::in_word_t  in_word   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               out_stall = 1'b0;
  i2a_pkg::out_word_t out_word_o;

  // characters still owed by the block, oldest first
  i2a_pkg::out_word_t expected_chars [$];
  i2a_pkg::out_word_t want;
  int unsigned mismatches    = 0;
  int unsigned numbers_taken = 0;
  int unsigned burst_left    = 0;
  int unsigned quiet_cycles  = 0;

  integer_to_ascii_formatter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // append one number's characters, flagging the final one
  function automatic void queue_chars(input logic [i2a_pkg::CHAR_W-1:0] chars [$]);
    i2a_pkg::out_word_t w;
    foreach (chars[i]) begin
      w.char_code = chars[i];
      w.last      = (i == chars.size() - 1);
      expected_chars.push_back(w);
    end
  endfunction

  // typed-in text from the directed table, leading zero bytes skipped
  function automatic void queue_typed_text(input logic [TEXT_W-1:0] text);
    logic [i2a_pkg::CHAR_W-1:0] chars [$];
    for (int i = MAX_CHARS - 1; i >= 0; i--) begin
      if (text[8*i +: 8] != 8'h00) begin
        chars.push_back(text[8*i +: i2a_pkg::CHAR_W]);
      end
    end
    queue_chars(chars);
  endfunction

  // predicted text of one number: digits are produced least significant first
  // and pushed to the front, the sign or the 0x prefix goes in last
  function automatic void format_number(input i2a_pkg::in_word_t w);
    logic [i2a_pkg::CHAR_W-1:0]  chars [$];
    logic [i2a_pkg::VALUE_W-1:0] mag;
    logic [3:0]                  nibble;
    if (w.op == i2a_pkg::OP_DEC) begin
      // magnitude in unsigned arithmetic, so the most negative value needs no care
      mag = w.value[i2a_pkg::VALUE_W-1] ? (32'd0 - w.value) : w.value;
      do begin
        chars.push_front(i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(mag % 32'd10));
        mag = mag / 32'd10;
      end while (mag != '0);
      if (w.value[i2a_pkg::VALUE_W-1]) begin
        chars.push_front(i2a_pkg::CH_MINUS);
      end
    end else begin
      mag = w.value;
      do begin
        nibble = mag[3:0];
        if (nibble < 4'd10) begin
          chars.push_front(i2a_pkg::CH_ZERO + i2a_pkg::CHAR_W'(nibble));
        end else begin
          chars.push_front(i2a_pkg::CH_A + i2a_pkg::CHAR_W'(nibble - 4'd10));
        end
        mag = mag >> 4;
      end while (mag != '0);
      chars.push_front(i2a_pkg::CH_X);
      chars.push_front(i2a_pkg::CH_ZERO);
    end
    queue_chars(chars);
  endfunction

  // offer one word on the input side; the producer works in bursts with random
  // gaps (sometimes none) so valid drops on every phase of the block's work
  task automatic offer_word(input i2a_pkg::in_word_t w, input logic [TEXT_W-1:0] text);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    // held until a rising edge finds stall low
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (text == '0) begin
      format_number(w);
    end else begin
      queue_typed_text(text);
    end
    numbers_taken++;
    burst_left--;
  endtask

  // producer: reset, directed table, random numbers, then drain and verdict
  initial begin : producer
    i2a_pkg::in_word_t w;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED_TABLE[i]) begin
      offer_word(DIRECTED_TABLE[i].word, DIRECTED_TABLE[i].text);
    end

    // values spread over every digit count: full range, short values,
    // negative short values, and neighbours of the powers of ten
    for (int n = 0; n < NUM_RANDOM; n++) begin
      w.op = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       w.value = $urandom;
        1:       w.value = $urandom >> $urandom_range(0, 31);
        2:       w.value = 32'd0 - ($urandom >> $urandom_range(0, 31));
        default: w.value = POW_TEN[$urandom_range(0, 9)] + $urandom_range(0, 2) - 32'd1;
      endcase
      offer_word(w, '0);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    // the watchdog bounds both waits
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // consumer: segments of differing stall styles, plus one long hold-off once
  // the producer is well under way, so the output register and the digit store
  // fill up and the block has to stall its input
  initial begin : consumer
    stall_style_e style;
    int unsigned  span;
    bit           held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && numbers_taken >= 40) begin
        held_off = 1'b1;
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      style = stall_style_e'($urandom_range(0, 3));
      span  = $urandom_range(10, 80);
      for (int tick = 0; tick < span; tick++) begin
        @(negedge clk_i);
        case (style)
          FLOW_FREE:  out_stall <= 1'b0;
          FLOW_COIN:  out_stall <= 1'($urandom_range(0, 1));
          FLOW_GATED: out_stall <= (tick % 4) != 0;
          default:    out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // every accepted output word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, got char_code %02h last %0b",
                 $time, out_word_o.char_code, out_word_o.last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_word_o.char_code !== want.char_code) begin
          $display("%0t: char_code expected %02h got %02h",
                   $time, want.char_code, out_word_o.char_code);
          mismatches++;
        end
        if (out_word_o.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_word_o.last);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles in which no word moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
        $display("%0t: timeout, no word accepted for %0d cycles, %0d characters owed",
                 $time, IDLE_LIMIT, expected_chars.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
